/* rtl/core/cpc_pkg.sv */
`default_nettype none
package cpc_pkg;
  localparam int NormalFracBits = 14;

  localparam int CoordW = 24;
  localparam int RadW   = 23;
  localparam int NormW  = 16;

  localparam int CentW = CoordW + 1;
  localparam int DiffW = CoordW + 2;
  localparam int SqW   = 2 * DiffW;
  localparam int RsW   = RadW + 1;
  localparam int D2W   = 2 * CoordW;
  localparam int RemW  = D2W + 1;
  localparam int QuoW  = 2 * NormalFracBits + 3;
  localparam int RootW = NormalFracBits + 2;
  localparam int QpW   = 2 * RootW;
  localparam int SRemW = RootW + 3;
  localparam int MagW  = NormalFracBits + 1;
  localparam int MulW  = MagW + RadW;
  localparam int VW    = CoordW + 2;

  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  typedef struct packed {
    logic                     hit;
    logic                     coinc;
    logic                     neg_x;
    logic                     neg_y;
    logic signed [CoordW-1:0] off_x;
    logic signed [CoordW-1:0] off_y;
    logic        [RadW-1:0]   ra;
  } side_t;
endpackage
`default_nettype wire

/* rtl/core/cpc_front.sv */
`default_nettype none
module cpc_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [cpc_pkg::CoordW-1:0] a_pos_x_i,
  input  logic signed [cpc_pkg::CoordW-1:0] a_pos_y_i,
  input  logic signed [cpc_pkg::CoordW-1:0] a_off_x_i,
  input  logic signed [cpc_pkg::CoordW-1:0] a_off_y_i,
  input  logic        [cpc_pkg::RadW-1:0]   a_radius_i,
  input  logic signed [cpc_pkg::CoordW-1:0] b_pos_x_i,
  input  logic signed [cpc_pkg::CoordW-1:0] b_pos_y_i,
  input  logic signed [cpc_pkg::CoordW-1:0] b_off_x_i,
  input  logic signed [cpc_pkg::CoordW-1:0] b_off_y_i,
  input  logic        [cpc_pkg::RadW-1:0]   b_radius_i,
  output logic                              valid_o,
  output cpc_pkg::side_t                    side_o,
  output logic        [cpc_pkg::D2W-1:0]    m2x_o,
  output logic        [cpc_pkg::D2W-1:0]    m2y_o,
  output logic        [cpc_pkg::D2W-1:0]    d2_o
);
  import cpc_pkg::*;

  logic [3:0] vld_q;

  logic signed [CentW-1:0] cax_q, cay_q, cbx_q, cby_q;
  logic        [RsW-1:0]   rs1_q, rs2_q;
  side_t                   s1_q, s2_q, s3_q, s4_q;
  logic        [DiffW-1:0] mx_q, my_q;
  logic        [SqW-1:0]   sqx_q, sqy_q;
  logic        [2*RsW-1:0] rsq_q;
  logic        [D2W-1:0]   m2x_q, m2y_q, d2_q;

  logic signed [DiffW-1:0] dx, dy;
  logic        [DiffW-1:0] mx_d, my_d;
  logic        [SqW:0]     d2f;
  side_t                   s1_d, s2_d, s4_d;

  always_comb begin
    s1_d       = '0;
    s1_d.off_x = a_off_x_i;
    s1_d.off_y = a_off_y_i;
    s1_d.ra    = a_radius_i;

    dx   = DiffW'(cax_q) - DiffW'(cbx_q);
    dy   = DiffW'(cay_q) - DiffW'(cby_q);
    mx_d = dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
    my_d = dy[DiffW-1] ? DiffW'(-dy) : DiffW'(dy);
    s2_d       = s1_q;
    s2_d.neg_x = dx[DiffW-1];
    s2_d.neg_y = dy[DiffW-1];

    d2f        = {1'b0, sqx_q} + {1'b0, sqy_q};
    s4_d       = s3_q;
    s4_d.hit   = d2f <= (SqW+1)'(rsq_q);
    s4_d.coinc = d2f == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cax_q <= CentW'(a_pos_x_i) + CentW'(a_off_x_i);
      cay_q <= CentW'(a_pos_y_i) + CentW'(a_off_y_i);
      cbx_q <= CentW'(b_pos_x_i) + CentW'(b_off_x_i);
      cby_q <= CentW'(b_pos_y_i) + CentW'(b_off_y_i);
      rs1_q <= {1'b0, a_radius_i} + {1'b0, b_radius_i};
      s1_q  <= s1_d;

      mx_q  <= mx_d;
      my_q  <= my_d;
      rs2_q <= rs1_q;
      s2_q  <= s2_d;

      sqx_q <= mx_q * mx_q;
      sqy_q <= my_q * my_q;
      rsq_q <= rs2_q * rs2_q;
      s3_q  <= s2_q;

      m2x_q <= sqx_q[D2W-1:0];
      m2y_q <= sqy_q[D2W-1:0];
      d2_q  <= d2f[D2W-1:0];
      s4_q  <= s4_d;
    end
  end

  assign valid_o = vld_q[3];
  assign side_o  = s4_q;
  assign m2x_o   = m2x_q;
  assign m2y_o   = m2y_q;
  assign d2_o    = d2_q;
endmodule
`default_nettype wire

/* rtl/core/cpc_div.sv */
`default_nettype none
module cpc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  cpc_pkg::side_t                side_i,
  input  logic [cpc_pkg::D2W-1:0]       m2x_i,
  input  logic [cpc_pkg::D2W-1:0]       m2y_i,
  input  logic [cpc_pkg::D2W-1:0]       d2_i,
  output logic                          valid_o,
  output cpc_pkg::side_t                side_o,
  output logic [cpc_pkg::QuoW-1:0]      qx_o,
  output logic [cpc_pkg::QuoW-1:0]      qy_o
);
  import cpc_pkg::*;

  // restoring divide of m2 * 2^(2NF+2) by d2, one quotient bit per stage
  function automatic logic [RemW:0] div_step(logic [RemW-1:0] r, logic [D2W-1:0] d);
    logic [RemW-1:0] de;
    logic            b;
    de = {1'b0, d};
    b  = r >= de;
    return {b, b ? r - de : r};
  endfunction

  logic [QuoW-1:0] vld_q;
  logic [RemW-1:0] rx_q [QuoW];
  logic [RemW-1:0] ry_q [QuoW];
  logic [QuoW-1:0] qx_q [QuoW];
  logic [QuoW-1:0] qy_q [QuoW];
  logic [D2W-1:0]  d_q  [QuoW];
  side_t           s_q  [QuoW];

  logic [RemW-1:0] rx_p [QuoW];
  logic [RemW-1:0] ry_p [QuoW];
  logic [QuoW-1:0] qx_p [QuoW];
  logic [QuoW-1:0] qy_p [QuoW];
  logic [D2W-1:0]  d_p  [QuoW];
  side_t           s_p  [QuoW];
  logic [RemW:0]   sx   [QuoW];
  logic [RemW:0]   sy   [QuoW];

  always_comb begin
    rx_p[0] = {1'b0, m2x_i};
    ry_p[0] = {1'b0, m2y_i};
    qx_p[0] = '0;
    qy_p[0] = '0;
    d_p[0]  = d2_i;
    s_p[0]  = side_i;
    for (int k = 1; k < QuoW; k++) begin
      rx_p[k] = {rx_q[k-1][RemW-2:0], 1'b0};
      ry_p[k] = {ry_q[k-1][RemW-2:0], 1'b0};
      qx_p[k] = qx_q[k-1];
      qy_p[k] = qy_q[k-1];
      d_p[k]  = d_q[k-1];
      s_p[k]  = s_q[k-1];
    end
    for (int k = 0; k < QuoW; k++) begin
      sx[k] = div_step(rx_p[k], d_p[k]);
      sy[k] = div_step(ry_p[k], d_p[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QuoW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QuoW; k++) begin
        rx_q[k] <= sx[k][RemW-1:0];
        ry_q[k] <= sy[k][RemW-1:0];
        qx_q[k] <= {qx_p[k][QuoW-2:0], sx[k][RemW]};
        qy_q[k] <= {qy_p[k][QuoW-2:0], sy[k][RemW]};
        d_q[k]  <= d_p[k];
        s_q[k]  <= s_p[k];
      end
    end
  end

  assign valid_o = vld_q[QuoW-1];
  assign side_o  = s_q[QuoW-1];
  assign qx_o    = qx_q[QuoW-1];
  assign qy_o    = qy_q[QuoW-1];
endmodule
`default_nettype wire

/* rtl/core/cpc_sqrt.sv */
`default_nettype none
module cpc_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  cpc_pkg::side_t                side_i,
  input  logic [cpc_pkg::QuoW-1:0]      qx_i,
  input  logic [cpc_pkg::QuoW-1:0]      qy_i,
  output logic                          valid_o,
  output cpc_pkg::side_t                side_o,
  output logic [cpc_pkg::RootW-1:0]     ux_o,
  output logic [cpc_pkg::RootW-1:0]     uy_o
);
  import cpc_pkg::*;

  // one root bit per stage, remainder form
  function automatic logic [SRemW+RootW-1:0] sq_step(logic [SRemW-1:0] rem,
                                                     logic [RootW-1:0] root,
                                                     logic [1:0]       pair);
    logic [SRemW-1:0] r;
    logic [SRemW-1:0] t;
    r = {rem[SRemW-3:0], pair};
    t = SRemW'({root, 2'b01});
    if (r >= t) begin
      return {r - t, root[RootW-2:0], 1'b1};
    end else begin
      return {r, root[RootW-2:0], 1'b0};
    end
  endfunction

  logic [RootW-1:0] vld_q;
  logic [QpW-1:0]   ax_q [RootW];
  logic [QpW-1:0]   ay_q [RootW];
  logic [SRemW-1:0] rx_q [RootW];
  logic [SRemW-1:0] ry_q [RootW];
  logic [RootW-1:0] tx_q [RootW];
  logic [RootW-1:0] ty_q [RootW];
  side_t            s_q  [RootW];

  logic [QpW-1:0]   ax_p [RootW];
  logic [QpW-1:0]   ay_p [RootW];
  logic [SRemW-1:0] rx_p [RootW];
  logic [SRemW-1:0] ry_p [RootW];
  logic [RootW-1:0] tx_p [RootW];
  logic [RootW-1:0] ty_p [RootW];
  side_t            s_p  [RootW];
  logic [SRemW+RootW-1:0] nx [RootW];
  logic [SRemW+RootW-1:0] ny [RootW];

  always_comb begin
    ax_p[0] = QpW'(qx_i);
    ay_p[0] = QpW'(qy_i);
    rx_p[0] = '0;
    ry_p[0] = '0;
    tx_p[0] = '0;
    ty_p[0] = '0;
    s_p[0]  = side_i;
    for (int k = 1; k < RootW; k++) begin
      ax_p[k] = ax_q[k-1];
      ay_p[k] = ay_q[k-1];
      rx_p[k] = rx_q[k-1];
      ry_p[k] = ry_q[k-1];
      tx_p[k] = tx_q[k-1];
      ty_p[k] = ty_q[k-1];
      s_p[k]  = s_q[k-1];
    end
    for (int k = 0; k < RootW; k++) begin
      nx[k] = sq_step(rx_p[k], tx_p[k], ax_p[k][2*(RootW-1-k) +: 2]);
      ny[k] = sq_step(ry_p[k], ty_p[k], ay_p[k][2*(RootW-1-k) +: 2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RootW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < RootW; k++) begin
        ax_q[k] <= ax_p[k];
        ay_q[k] <= ay_p[k];
        rx_q[k] <= nx[k][SRemW+RootW-1:RootW];
        ry_q[k] <= ny[k][SRemW+RootW-1:RootW];
        tx_q[k] <= nx[k][RootW-1:0];
        ty_q[k] <= ny[k][RootW-1:0];
        s_q[k]  <= s_p[k];
      end
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign side_o  = s_q[RootW-1];
  assign ux_o    = tx_q[RootW-1];
  assign uy_o    = ty_q[RootW-1];
endmodule
`default_nettype wire

/* rtl/core/cpc_contact.sv */
`default_nettype none
module cpc_contact (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  cpc_pkg::side_t                    side_i,
  input  logic        [cpc_pkg::RootW-1:0]  ux_i,
  input  logic        [cpc_pkg::RootW-1:0]  uy_i,
  output logic                              valid_o,
  output logic                              hit_o,
  output logic                              coincident_o,
  output logic signed [cpc_pkg::NormW-1:0]  normal_x_o,
  output logic signed [cpc_pkg::NormW-1:0]  normal_y_o,
  output logic signed [cpc_pkg::CoordW-1:0] contact_x_o,
  output logic signed [cpc_pkg::CoordW-1:0] contact_y_o
);
  import cpc_pkg::*;

  localparam logic [MulW:0] Half = (MulW+1)'(1) << (NormalFracBits - 1);

  function automatic logic signed [CoordW-1:0] place(logic [MulW-1:0] prod,
                                                     logic neg,
                                                     logic signed [CoordW-1:0] off);
    logic [MulW:0]          rs;
    logic signed [VW-1:0]   pe;
    logic signed [VW-1:0]   v;
    rs = {1'b0, prod} + Half;
    pe = $signed(VW'(rs[MulW:NormalFracBits]));
    v  = VW'(off) + (neg ? -pe : pe);
    if (v > VW'(CoordMax)) begin
      return CoordMax;
    end else if (v < VW'(CoordMin)) begin
      return CoordMin;
    end else begin
      return v[CoordW-1:0];
    end
  endfunction

  logic [1:0]       vld_q;
  side_t            s1_q;
  logic [MagW-1:0]  cx_q, cy_q;
  logic [MulW-1:0]  px_q, py_q;

  logic             hit_q, coinc_q;
  logic signed [NormW-1:0]  nx_q, ny_q;
  logic signed [CoordW-1:0] kx_q, ky_q;

  logic [RootW:0]   sx, sy;
  logic [MagW-1:0]  cx_d, cy_d;
  logic             live;
  logic signed [NormW-1:0] mx, my;

  always_comb begin
    sx   = {1'b0, ux_i} + (RootW+1)'(1);
    sy   = {1'b0, uy_i} + (RootW+1)'(1);
    live = side_i.hit && !side_i.coinc;
    cx_d = live ? sx[MagW:1] : '0;
    cy_d = live ? sy[MagW:1] : '0;
    mx   = $signed(NormW'(cx_q));
    my   = $signed(NormW'(cy_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= side_i;
      cx_q <= cx_d;
      cy_q <= cy_d;
      px_q <= cx_d * side_i.ra;
      py_q <= cy_d * side_i.ra;

      hit_q   <= s1_q.hit;
      coinc_q <= s1_q.hit && s1_q.coinc;
      nx_q    <= s1_q.neg_x ? -mx : mx;
      ny_q    <= s1_q.neg_y ? -my : my;
      kx_q    <= s1_q.hit ? place(px_q, s1_q.neg_x, s1_q.off_x) : '0;
      ky_q    <= s1_q.hit ? place(py_q, s1_q.neg_y, s1_q.off_y) : '0;
    end
  end

  assign valid_o      = vld_q[1];
  assign hit_o        = hit_q;
  assign coincident_o = coinc_q;
  assign normal_x_o   = nx_q;
  assign normal_y_o   = ny_q;
  assign contact_x_o  = kx_q;
  assign contact_y_o  = ky_q;
endmodule
`default_nettype wire

/* rtl/core/circle_pair_contact_core.sv */
// channel | handshake             | payload
// --------+-----------------------+--------------------------------------------
// in      | in_valid_i/in_ready_o | a_pos/a_off/a_radius, b_pos/b_off/b_radius
// out     | out_valid_o/out_ready_i | hit, coincident, normal_x/y, contact_x/y
//
// One item per cycle while the output is not stalled. The pipeline stages are
// four front stages, one divider stage per quotient bit, one root stage per bit,
// two stages for the contact point. All stages advance together; a stalled
// output holds the whole pipe. Reset clears only the valid bits.
`default_nettype none
module circle_pair_contact_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [cpc_pkg::CoordW-1:0] a_pos_x_i,
  input  logic signed [cpc_pkg::CoordW-1:0] a_pos_y_i,
  input  logic signed [cpc_pkg::CoordW-1:0] a_off_x_i,
  input  logic signed [cpc_pkg::CoordW-1:0] a_off_y_i,
  input  logic        [cpc_pkg::RadW-1:0]   a_radius_i,
  input  logic signed [cpc_pkg::CoordW-1:0] b_pos_x_i,
  input  logic signed [cpc_pkg::CoordW-1:0] b_pos_y_i,
  input  logic signed [cpc_pkg::CoordW-1:0] b_off_x_i,
  input  logic signed [cpc_pkg::CoordW-1:0] b_off_y_i,
  input  logic        [cpc_pkg::RadW-1:0]   b_radius_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic                              coincident_o,
  output logic signed [cpc_pkg::NormW-1:0]  normal_x_o,
  output logic signed [cpc_pkg::NormW-1:0]  normal_y_o,
  output logic signed [cpc_pkg::CoordW-1:0] contact_x_o,
  output logic signed [cpc_pkg::CoordW-1:0] contact_y_o
);
  import cpc_pkg::*;

  logic en;
  logic f_vld, d_vld, s_vld;
  side_t f_side, d_side, s_side;
  logic [D2W-1:0]   m2x, m2y, d2;
  logic [QuoW-1:0]  qx, qy;
  logic [RootW-1:0] ux, uy;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  cpc_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .a_pos_x_i, .a_pos_y_i, .a_off_x_i, .a_off_y_i, .a_radius_i,
    .b_pos_x_i, .b_pos_y_i, .b_off_x_i, .b_off_y_i, .b_radius_i,
    .valid_o(f_vld), .side_o(f_side), .m2x_o(m2x), .m2y_o(m2y), .d2_o(d2)
  );

  cpc_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_vld), .side_i(f_side),
    .m2x_i(m2x), .m2y_i(m2y), .d2_i(d2),
    .valid_o(d_vld), .side_o(d_side), .qx_o(qx), .qy_o(qy)
  );

  cpc_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d_vld), .side_i(d_side),
    .qx_i(qx), .qy_i(qy),
    .valid_o(s_vld), .side_o(s_side), .ux_o(ux), .uy_o(uy)
  );

  cpc_contact u_contact (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_vld), .side_i(s_side),
    .ux_i(ux), .uy_i(uy),
    .valid_o(out_valid_o), .hit_o, .coincident_o,
    .normal_x_o, .normal_y_o, .contact_x_o, .contact_y_o
  );
endmodule
`default_nettype wire

/* rtl/core/cpc_checker.sv */
`default_nettype none
module cpc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic signed [cpc_pkg::CoordW-1:0] a_pos_x_i,
  input logic signed [cpc_pkg::CoordW-1:0] a_pos_y_i,
  input logic signed [cpc_pkg::CoordW-1:0] a_off_x_i,
  input logic signed [cpc_pkg::CoordW-1:0] a_off_y_i,
  input logic        [cpc_pkg::RadW-1:0]   a_radius_i,
  input logic signed [cpc_pkg::CoordW-1:0] b_pos_x_i,
  input logic signed [cpc_pkg::CoordW-1:0] b_pos_y_i,
  input logic signed [cpc_pkg::CoordW-1:0] b_off_x_i,
  input logic signed [cpc_pkg::CoordW-1:0] b_off_y_i,
  input logic        [cpc_pkg::RadW-1:0]   b_radius_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              hit_o,
  input logic                              coincident_o,
  input logic signed [cpc_pkg::NormW-1:0]  normal_x_o,
  input logic signed [cpc_pkg::NormW-1:0]  normal_y_o,
  input logic signed [cpc_pkg::CoordW-1:0] contact_x_o,
  input logic signed [cpc_pkg::CoordW-1:0] contact_y_o
);
  import cpc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({hit_o, coincident_o, normal_x_o, normal_y_o, contact_x_o, contact_y_o}))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> !coincident_o && normal_x_o == '0 && normal_y_o == '0 &&
      contact_x_o == '0 && contact_y_o == '0)
    else $error("miss with nonzero fields");

  a_coinc_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && coincident_o |-> hit_o && normal_x_o == '0 && normal_y_o == '0)
    else $error("coincident item with nonzero normal");

  a_hit_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o && !coincident_o |-> (normal_x_o != '0 || normal_y_o != '0))
    else $error("hit with zero normal");

  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> normal_x_o <= $signed(NormW'(1 << NormalFracBits)) &&
      normal_x_o >= -$signed(NormW'(1 << NormalFracBits)) &&
      normal_y_o <= $signed(NormW'(1 << NormalFracBits)) &&
      normal_y_o >= -$signed(NormW'(1 << NormalFracBits)))
    else $error("normal out of range");
endmodule

bind circle_pair_contact_core cpc_checker u_cpc_checker (.*);
`default_nettype wire

/* verif/circle_pair_contact_checker.sv */
module circle_pair_contact_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic signed [cpc_pkg::CoordW-1:0] a_pos_x_i,
  input  logic signed [cpc_pkg::CoordW-1:0] a_pos_y_i,
  input  logic signed [cpc_pkg::CoordW-1:0] a_off_x_i,
  input  logic signed [cpc_pkg::CoordW-1:0] a_off_y_i,
  input  logic        [cpc_pkg::RadW-1:0]   a_radius_i,
  input  logic signed [cpc_pkg::CoordW-1:0] b_pos_x_i,
  input  logic signed [cpc_pkg::CoordW-1:0] b_pos_y_i,
  input  logic signed [cpc_pkg::CoordW-1:0] b_off_x_i,
  input  logic signed [cpc_pkg::CoordW-1:0] b_off_y_i,
  input  logic        [cpc_pkg::RadW-1:0]   b_radius_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic                              hit_i,
  input  logic                              coincident_i,
  input  logic signed [cpc_pkg::NormW-1:0]  normal_x_i,
  input  logic signed [cpc_pkg::NormW-1:0]  normal_y_i,
  input  logic signed [cpc_pkg::CoordW-1:0] contact_x_i,
  input  logic signed [cpc_pkg::CoordW-1:0] contact_y_i,
  output int                                fail_cnt_o,
  output int                                pending_o,
  output int                                hit_cnt_o,
  output int                                coinc_cnt_o
);
  import cpc_pkg::*;

  localparam int NF = NormalFracBits;

  typedef struct packed {
    logic                     hit;
    logic                     coinc;
    logic signed [NormW-1:0]  nx;
    logic signed [NormW-1:0]  ny;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
  } contact_t;

  contact_t contact_q[$];

  function automatic logic [63:0] unit_mag(logic [63:0] m, logic [63:0] d2);
    logic [63:0]  q, c, t;
    logic [127:0] lhs, rhs;
    q = 0;
    for (int bi = NF; bi >= 0; bi--) begin
      c = q | (64'd1 << bi);
      t = 2 * c - 1;
      lhs = 128'(t * t) * 128'(d2);
      rhs = 128'(m * m) * (128'd1 << (2 * NF + 2));
      if (lhs <= rhs) q = c;
    end
    return q;
  endfunction

  function automatic logic [CoordW-1:0] contact_comp(longint n, longint r, longint off);
    longint mg, p, v;
    mg = (n < 0) ? -n : n;
    p = (mg * r + (64'd1 << (NF - 1))) >>> NF;
    v = off + ((n < 0) ? -p : p);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[CoordW-1:0];
  endfunction

  function automatic contact_t predict_contact();
    contact_t    e;
    longint      ax, ay, bx, by, dx, dy, nx, ny, ra, rb;
    logic [63:0] mx, my, d2, rs;
    ax = longint'(a_pos_x_i) + longint'(a_off_x_i);
    ay = longint'(a_pos_y_i) + longint'(a_off_y_i);
    bx = longint'(b_pos_x_i) + longint'(b_off_x_i);
    by = longint'(b_pos_y_i) + longint'(b_off_y_i);
    ra = longint'({1'b0, a_radius_i});
    rb = longint'({1'b0, b_radius_i});
    dx = ax - bx;
    dy = ay - by;
    mx = (dx < 0) ? -dx : dx;
    my = (dy < 0) ? -dy : dy;
    d2 = mx * mx + my * my;
    rs = ra + rb;
    e = '0;
    if (d2 > rs * rs) return e;
    e.hit = 1'b1;
    nx = 0;
    ny = 0;
    if (d2 == 0) begin
      e.coinc = 1'b1;
    end else begin
      nx = unit_mag(mx, d2);
      ny = unit_mag(my, d2);
      if (dx < 0) nx = -nx;
      if (dy < 0) ny = -ny;
    end
    e.nx = nx[NormW-1:0];
    e.ny = ny[NormW-1:0];
    e.cx = contact_comp(nx, ra, longint'(a_off_x_i));
    e.cy = contact_comp(ny, ra, longint'(a_off_y_i));
    return e;
  endfunction

  initial begin
    fail_cnt_o = 0;
    hit_cnt_o = 0;
    coinc_cnt_o = 0;
  end

  assign pending_o = contact_q.size();

  always @(posedge clk_i) begin
    contact_t e;
    if (rst_ni && in_valid_i && in_ready_i) contact_q.push_back(predict_contact());
    if (rst_ni && out_valid_i && out_ready_i) begin
      if (contact_q.size() == 0) begin
        $display("%0t: result with no item pending: %h %h %h %h %h %h", $time,
                 hit_i, coincident_i, normal_x_i, normal_y_i, contact_x_i, contact_y_i);
        fail_cnt_o++;
      end else begin
        e = contact_q.pop_front();
        hit_cnt_o += e.hit;
        coinc_cnt_o += e.coinc;
        if (hit_i !== e.hit) begin
          $display("%0t: hit exp %0d got %0d", $time, e.hit, hit_i);
          fail_cnt_o++;
        end
        if (coincident_i !== e.coinc) begin
          $display("%0t: coincident exp %0d got %0d", $time, e.coinc, coincident_i);
          fail_cnt_o++;
        end
        if (normal_x_i !== e.nx) begin
          $display("%0t: normal_x exp %0d got %0d", $time, e.nx, normal_x_i);
          fail_cnt_o++;
        end
        if (normal_y_i !== e.ny) begin
          $display("%0t: normal_y exp %0d got %0d", $time, e.ny, normal_y_i);
          fail_cnt_o++;
        end
        if (contact_x_i !== e.cx) begin
          $display("%0t: contact_x exp %0d got %0d", $time, e.cx, contact_x_i);
          fail_cnt_o++;
        end
        if (contact_y_i !== e.cy) begin
          $display("%0t: contact_y exp %0d got %0d", $time, e.cy, contact_y_i);
          fail_cnt_o++;
        end
      end
    end
  end
endmodule

/* verif/tb.sv */
module tb;
  import cpc_pkg::*;

  localparam int WatchLimit = 4000;
  localparam int NumRandom = 1030;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CoordW-1:0] apx = '0, apy = '0, aox = '0, aoy = '0;
  logic signed [CoordW-1:0] bpx = '0, bpy = '0, box = '0, boy = '0;
  logic [RadW-1:0] ar = '0, br = '0;
  logic hit, coinc;
  logic signed [NormW-1:0] nx, ny;
  logic signed [CoordW-1:0] cx, cy;
  int fails, pending, hits, coincs;
  int items = 0;
  int idle_cnt = 0;
  bit quiet = 1'b0;

  always #5 clk_i = ~clk_i;

  circle_pair_contact_core uut (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_ready_o(in_ready),
    .a_pos_x_i(apx), .a_pos_y_i(apy), .a_off_x_i(aox), .a_off_y_i(aoy), .a_radius_i(ar),
    .b_pos_x_i(bpx), .b_pos_y_i(bpy), .b_off_x_i(box), .b_off_y_i(boy), .b_radius_i(br),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .hit_o(hit), .coincident_o(coinc),
    .normal_x_o(nx), .normal_y_o(ny), .contact_x_o(cx), .contact_y_o(cy)
  );

  circle_pair_contact_checker chk (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_ready_i(in_ready),
    .a_pos_x_i(apx), .a_pos_y_i(apy), .a_off_x_i(aox), .a_off_y_i(aoy), .a_radius_i(ar),
    .b_pos_x_i(bpx), .b_pos_y_i(bpy), .b_off_x_i(box), .b_off_y_i(boy), .b_radius_i(br),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .hit_i(hit), .coincident_i(coinc),
    .normal_x_i(nx), .normal_y_i(ny), .contact_x_i(cx), .contact_y_i(cy),
    .fail_cnt_o(fails), .pending_o(pending), .hit_cnt_o(hits), .coinc_cnt_o(coincs)
  );

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WatchLimit) begin
      $display("watchdog expired, %0d results pending", pending);
      $display("circle_pair_contact_core verification failed");
      $finish;
    end
  end

  initial begin
    int n;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        n = $urandom_range(1, 14);
        out_ready <= ($urandom_range(0, 2) != 0);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  task automatic send_pair(logic [23:0] pax, pay, oax, oay, logic [22:0] ra,
                           logic [23:0] pbx, pby, obx, oby, logic [22:0] rb);
    apx <= pax; apy <= pay; aox <= oax; aoy <= oay; ar <= ra;
    bpx <= pbx; bpy <= pby; box <= obx; boy <= oby; br <= rb;
    in_valid <= 1'b1;
    do @(negedge clk_i); while (!in_ready);
    @(posedge clk_i);
    items++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_near();
    int k;
    longint cax, cay, ddx, ddy, obx, oby;
    logic [22:0] ra, rb;
    k = $urandom_range(2, 22);
    cax = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
    cay = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
    ddx = $signed($urandom_range(0, 1 << k)) - (1 << (k - 1));
    ddy = $signed($urandom_range(0, 1 << k)) - (1 << (k - 1));
    if ($urandom_range(0, 15) == 0) begin
      ddx = 0;
      ddy = 0;
    end
    obx = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    oby = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    ra = 23'($urandom_range(0, 1 << k));
    rb = 23'($urandom_range(0, 1 << k));
    if ($urandom_range(0, 7) == 0) ra = 23'($urandom);
    send_pair(24'(cax - obx - 100), 24'(cay + 37), 24'(obx + 100), 24'(oby - 37), ra,
              24'(cax - ddx - obx), 24'(cay - ddy - oby), 24'(obx), 24'(oby), rb);
  endtask

  initial begin
    logic [23:0] mx, mn;
    mx = 24'h7fffff;
    mn = 24'h800000;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(mx, mx, mx, mx, 23'h7fffff, mn, mn, mn, mn, 23'h7fffff);
    send_pair(mn, mn, mn, mn, 23'h7fffff, mx, mx, mx, mx, 23'h7fffff);
    send_pair(mx, mn, mx, mn, 23'h7fffff, mx, mn, mx, mn, 0);
    send_pair(mx, mx, mx, mx, 23'h7fffff, mx, mx, mx, mx, 23'h7fffff);
    send_pair(0, 0, mx, mn, 23'h7fffff, 0, 0, mx, mn, 0);
    send_pair(768, 1024, 0, 0, 512, 0, 0, 0, 0, 768);
    send_pair(768, 1024, 0, 0, 512, 0, 0, 0, 0, 767);
    send_pair(0, 0, 0, 0, 100, 1000, 0, 0, 0, 900);
    send_pair(0, 0, 0, 0, 100, 0, -1000, 0, 0, 900);
    send_pair(0, 0, 0, 0, 100, -1000, 0, 0, 0, 900);
    send_pair(0, 0, mx - 10, mn + 10, 23'h7fffff, mn, mx, 0, 0, 23'h7fffff);
    send_pair(0, 0, mn + 10, mx - 10, 23'h7fffff, 0, 0, mx, mn, 23'h7fffff);
    send_pair(1, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    send_pair(1, 1, 0, 0, 1, 0, 0, 0, 0, 1);
    send_pair(-1, -1, 0, 0, 1, 0, 0, 0, 0, 1);
    send_pair(100, 100, 0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(3, 1, 0, 0, 23'h7fffff, 0, 0, 0, 0, 0);
    drain();
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 2) drain();
      if (i == NumRandom - 120) quiet = 1'b1;
      if ($urandom_range(0, 4) == 0)
        send_pair(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                  23'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom), 23'($urandom));
      else
        send_near();
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    $display("sent %0d circle pairs: %0d hits, %0d coincident centers", items, hits, coincs);
    $display("included full-range random pairs, near-contact pairs and both-side stalls");
    if (fails == 0) begin
      $display("circle_pair_contact_core verification clean");
    end else begin
      $display("circle_pair_contact_core verification failed");
    end
    $finish;
  end
endmodule
